[rtl/grid_edge_range_index_assert.svh]
// Assertion macros for the checker file of the grid edge range index.
// Needs nothing else; each macro takes the clock and reset to sample on.
`ifndef GRID_EDGE_RANGE_INDEX_ASSERT_SVH
`define GRID_EDGE_RANGE_INDEX_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define GEI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset
`define GEI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[rtl/gei_pkg.sv]
// Shared types and constants of the grid edge range index.
// Used by gei_front, gei_engine, the top level and the checkers; depends on nothing.
`default_nettype none
package gei_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_WIDTH    = 2'd2;
  localparam logic [1:0] CFG_HEIGHT   = 2'd3;

  localparam logic [15:0] EDGE_MAX = 16'hFFFF;
  // Cell bounds travel at this width; covers a grid side up to 511
  localparam int COORD_W = 9;

  typedef struct packed {
    logic [15:0] chain;
    logic [15:0] start;
    logic [15:0] stop;
  } slot_t;

  typedef struct packed {
    action_t             action;
    logic                span_empty;
    logic [COORD_W-1:0]  x0;
    logic [COORD_W-1:0]  x1;
    logic [COORD_W-1:0]  y0;
    logic [COORD_W-1:0]  y1;
    logic [15:0]         chain_id;
    logic [15:0]         edge_index;
  } cmd_t;

  typedef struct packed {
    logic        has_entry;
    logic [15:0] found_chain;
    logic [15:0] range_start;
    logic [15:0] range_end;
    logic        last;
    logic [1:0]  status;
  } result_t;

endpackage
`default_nettype wire

[rtl/gei_fifo.sv]
// Small first-in first-out queue of flop entries.
// Generic; used between front and engine and on the result side.
`default_nettype none
module gei_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem[rp];

  // Advance pointers and count on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) wp <= (wp == PW'(DEPTH - 1)) ? '0 : PW'(wp + 1'b1);
      if (do_rd) rp <= (rp == PW'(DEPTH - 1)) ? '0 : PW'(rp + 1'b1);
      if (do_wr & ~do_rd) count <= CW'(count + 1'b1);
      else if (do_rd & ~do_wr) count <= CW'(count - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_data;
  end
endmodule
`default_nettype wire

[rtl/gei_front.sv]
// Front end: accepts items and turns the two points into clamped cell bounds.
// Uses gei_pkg; feeds the command queue in front of the engine.
`default_nettype none
module gei_front #(
  parameter int GRID_SIDE = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [1:0]          action,
  input  wire logic signed [23:0]  point_a_x,
  input  wire logic signed [23:0]  point_a_y,
  input  wire logic signed [23:0]  point_b_x,
  input  wire logic signed [23:0]  point_b_y,
  input  wire logic [15:0]         chain_id,
  input  wire logic [15:0]         edge_index,
  input  wire logic signed [17:0]  origin_x,
  input  wire logic signed [17:0]  origin_y,
  input  wire logic [5:0]          size_x,
  input  wire logic [5:0]          size_y,
  output gei_pkg::cmd_t            cmd,
  output logic                     cmd_push,
  input  wire logic                cmd_full
);
  import gei_pkg::*;

  localparam logic signed [20:0] SIDE_L = 21'(GRID_SIDE);

  // Stage 1: raw item
  logic               s1_v;
  action_t            s1_act;
  logic signed [23:0] s1_ax, s1_ay, s1_bx, s1_by;
  logic [15:0]        s1_chain, s1_edge;
  // Stage 2: unclamped bounds
  logic               s2_v;
  action_t            s2_act;
  logic signed [20:0] s2_x0, s2_x1, s2_y0, s2_y1;
  logic [15:0]        s2_chain, s2_edge;

  logic               s2_free, s1_move, accept;
  logic signed [20:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [20:0] lim_x, lim_y;
  logic signed [20:0] c0x, c1x, c0y, c1y;

  function automatic logic signed [20:0] lo_cell(
    input logic signed [23:0] a, input logic signed [23:0] b,
    input logic signed [17:0] org
  );
    logic signed [23:0] lo;
    logic signed [17:0] fl;
    lo = (a < b) ? a : b;
    fl = lo[23:6];
    return {{3{fl[17]}}, fl} - {{3{org[17]}}, org};
  endfunction

  function automatic logic signed [20:0] hi_cell(
    input logic signed [23:0] a, input logic signed [23:0] b,
    input logic signed [17:0] org
  );
    logic signed [23:0] hi;
    logic signed [24:0] sum;
    hi  = (a < b) ? b : a;
    sum = {hi[23], hi} + 25'sd63;
    return {{2{sum[24]}}, sum[24:6]} - {{3{org[17]}}, org};
  endfunction

  assign s2_free  = ~s2_v | ~cmd_full;
  assign s1_move  = s1_v & s2_free;
  assign full     = s1_v & ~s2_free;
  assign accept   = push & ~full;
  assign cmd_push = s2_v;

  // Clamp against the used grid size
  assign lim_x = (21'(size_x) > SIDE_L) ? SIDE_L : 21'(size_x);
  assign lim_y = (21'(size_y) > SIDE_L) ? SIDE_L : 21'(size_y);
  assign lo_x  = s2_x0;
  assign hi_x  = s2_x1;
  assign lo_y  = s2_y0;
  assign hi_y  = s2_y1;
  assign c0x   = (lo_x < 0) ? '0 : lo_x;
  assign c1x   = (hi_x > lim_x) ? lim_x : hi_x;
  assign c0y   = (lo_y < 0) ? '0 : lo_y;
  assign c1y   = (hi_y > lim_y) ? lim_y : hi_y;

  always_comb begin
    cmd.action     = s2_act;
    cmd.span_empty = (c1x <= c0x) | (c1y <= c0y);
    cmd.x0         = c0x[COORD_W-1:0];
    cmd.x1         = c1x[COORD_W-1:0];
    cmd.y0         = c0y[COORD_W-1:0];
    cmd.y1         = c1y[COORD_W-1:0];
    cmd.chain_id   = s2_chain;
    cmd.edge_index = s2_edge;
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (s1_move | ~s1_v) s1_v <= accept;
      if (s2_free) s2_v <= s1_move;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act   <= action_t'(action);
      s1_ax    <= point_a_x;
      s1_ay    <= point_a_y;
      s1_bx    <= point_b_x;
      s1_by    <= point_b_y;
      s1_chain <= chain_id;
      s1_edge  <= edge_index;
    end
    if (s1_move) begin
      s2_act   <= s1_act;
      s2_x0    <= lo_cell(s1_ax, s1_bx, origin_x);
      s2_x1    <= hi_cell(s1_ax, s1_bx, origin_x);
      s2_y0    <= lo_cell(s1_ay, s1_by, origin_y);
      s2_y1    <= hi_cell(s1_ay, s1_by, origin_y);
      s2_chain <= s1_chain;
      s2_edge  <= s1_edge;
    end
  end
endmodule
`default_nettype wire

[rtl/gei_engine.sv]
// Back end: sequencer over the cell memories, insert, query merge and clear.
// Uses gei_pkg; takes commands from the front queue, pushes result records.
`default_nettype none
module gei_engine #(
  parameter int GRID_SIDE      = 32,
  parameter int SLOTS_PER_CELL = 8,
  parameter int MAX_RESULTS    = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire gei_pkg::cmd_t cmd,
  input  wire logic         cmd_empty,
  output logic              cmd_pop,
  output gei_pkg::result_t  res,
  output logic              res_push,
  input  wire logic         res_full,
  output logic              init_busy
);
  import gei_pkg::*;

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SAW   = (CELLS * SLOTS_PER_CELL > 1) ? $clog2(CELLS * SLOTS_PER_CELL) : 1;
  localparam int XW    = $clog2(GRID_SIDE + 1);
  localparam int FW    = $clog2(SLOTS_PER_CELL + 1);
  localparam int MW    = $clog2(MAX_RESULTS + 1);
  localparam int MIW   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int SUMW  = ((MW > FW) ? MW : FW) + 1;
  localparam logic [AW-1:0]  SIDE_A  = AW'(GRID_SIDE);
  localparam logic [SAW-1:0] SLOTS_A = SAW'(SLOTS_PER_CELL);

  typedef enum logic [13:0] {
    S_CLR      = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_FILL_RD  = 14'b00000000000100,
    S_FILL_CHK = 14'b00000000001000,
    S_SLOT_RD  = 14'b00000000010000,
    S_SLOT_CHK = 14'b00000000100000,
    S_INS_END  = 14'b00000001000000,
    S_MB_RD    = 14'b00000010000000,
    S_MB_CHK   = 14'b00000100000000,
    S_NEXT     = 14'b00001000000000,
    S_END      = 14'b00010000000000,
    S_EMIT_RD  = 14'b00100000000000,
    S_EMIT     = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } state_t;

  logic [FW-1:0] fill_mem [CELLS];
  slot_t         slot_mem [CELLS * SLOTS_PER_CELL];
  slot_t         mb_mem   [MAX_RESULTS];

  state_t        state;
  cmd_t          job;
  logic          clr_reply;
  logic [AW-1:0] clr_cnt;
  logic [XW-1:0] x, y;
  logic [FW-1:0] fill_n, slot_i;
  logic [MW-1:0] mc, mj;
  logic [1:0]    status_r;
  slot_t         cur;
  logic [FW-1:0] fill_q;
  slot_t         slot_q, mb_q;

  logic            ins, hit_slot, mb_hit, ins_room, last_slot, last_j, over;
  logic [15:0]     eend;
  logic [AW-1:0]   cell_addr;
  logic [SAW-1:0]  slot_raddr, slot_base;
  logic            fill_we, slot_we, mb_we;
  logic [AW-1:0]   fill_waddr;
  logic [FW-1:0]   fill_wdata;
  logic [SAW-1:0]  slot_waddr;
  slot_t           slot_wdata, mb_wdata, ins_new;
  logic [MIW-1:0]  mb_waddr;
  logic [SUMW-1:0] need;

  function automatic slot_t widen(input slot_t s, input slot_t t);
    slot_t r;
    r       = s;
    r.start = (t.start < s.start) ? t.start : s.start;
    r.stop  = (t.stop > s.stop) ? t.stop : s.stop;
    return r;
  endfunction

  assign ins       = (job.action == ACT_INSERT);
  assign eend      = (job.edge_index == EDGE_MAX) ? EDGE_MAX : 16'(job.edge_index + 1'b1);
  assign ins_new   = '{chain: job.chain_id, start: job.edge_index, stop: eend};
  assign cell_addr = AW'(AW'(y) * SIDE_A + AW'(x));
  assign slot_base = SAW'(SAW'(cell_addr) * SLOTS_A);
  assign slot_raddr = SAW'(slot_base + SAW'(slot_i));
  assign hit_slot  = (slot_q.chain == job.chain_id);
  assign mb_hit    = (mb_q.chain == cur.chain);
  assign ins_room  = (fill_n < FW'(SLOTS_PER_CELL));
  assign last_slot = (FW'(slot_i + 1'b1) == fill_n);
  assign last_j    = (MW'(mj + 1'b1) == mc);
  assign need      = SUMW'(mc) + SUMW'(fill_q);
  assign over      = (need > SUMW'(MAX_RESULTS));
  assign init_busy = (state == S_CLR) & ~clr_reply;
  assign cmd_pop   = (state == S_IDLE) & ~cmd_empty;

  // Memory write ports
  always_comb begin
    fill_we    = (state == S_CLR) | ((state == S_INS_END) & ins_room);
    fill_waddr = (state == S_CLR) ? clr_cnt : cell_addr;
    fill_wdata = (state == S_CLR) ? '0 : FW'(fill_n + 1'b1);
    slot_we    = ((state == S_SLOT_CHK) & ins & hit_slot) |
                 ((state == S_INS_END) & ins_room);
    slot_waddr = (state == S_INS_END) ? SAW'(slot_base + SAW'(fill_n)) : slot_raddr;
    slot_wdata = (state == S_INS_END) ? ins_new : widen(slot_q, ins_new);
    mb_we      = ((state == S_SLOT_CHK) & ~ins & (mc == '0)) |
                 ((state == S_MB_CHK) & (mb_hit | last_j));
    mb_waddr   = ((state == S_MB_CHK) & mb_hit) ? mj[MIW-1:0] : mc[MIW-1:0];
    if (state == S_SLOT_CHK) mb_wdata = slot_q;
    else if (mb_hit)         mb_wdata = widen(mb_q, cur);
    else                     mb_wdata = cur;
  end

  // Memories with registered reads
  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_q <= fill_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (mb_we) mb_mem[mb_waddr] <= mb_wdata;
    mb_q <= mb_mem[mj[MIW-1:0]];
  end

  // Result record
  always_comb begin
    res_push        = 1'b0;
    res.has_entry   = 1'b0;
    res.found_chain = '0;
    res.range_start = '0;
    res.range_end   = '0;
    res.last        = 1'b1;
    res.status      = status_r;
    if (state == S_EMIT) begin
      res_push        = 1'b1;
      res.has_entry   = 1'b1;
      res.found_chain = mb_q.chain;
      res.range_start = mb_q.start;
      res.range_end   = mb_q.stop;
      res.last        = last_j;
      res.status      = ST_OK;
    end else if (state == S_DONE) begin
      res_push = 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_reply <= 1'b0;
      clr_cnt   <= '0;
      mc        <= '0;
      mj        <= '0;
      status_r  <= ST_OK;
    end else begin
      case (state)
        S_CLR: begin
          if (clr_cnt == AW'(CELLS - 1)) begin
            clr_cnt <= '0;
            state   <= clr_reply ? S_DONE : S_IDLE;
          end else clr_cnt <= AW'(clr_cnt + 1'b1);
        end
        S_IDLE: begin
          if (!cmd_empty) begin
            job      <= cmd;
            mc       <= '0;
            status_r <= ST_OK;
            x        <= cmd.x0[XW-1:0];
            y        <= cmd.y0[XW-1:0];
            case (cmd.action)
              ACT_CLEAR: begin
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
              ACT_INSERT, ACT_QUERY: state <= cmd.span_empty ? S_END : S_FILL_RD;
              default: state <= S_DONE;
            endcase
          end
        end
        S_FILL_RD: state <= S_FILL_CHK;
        S_FILL_CHK: begin
          fill_n <= fill_q;
          slot_i <= '0;
          if (ins) state <= (fill_q == '0) ? S_INS_END : S_SLOT_RD;
          else if (fill_q == '0) state <= S_NEXT;
          else if (over) begin
            status_r <= ST_OVERFLOW;
            state    <= S_DONE;
          end else state <= S_SLOT_RD;
        end
        S_SLOT_RD: state <= S_SLOT_CHK;
        S_SLOT_CHK: begin
          if (ins) begin
            if (hit_slot) state <= S_NEXT;
            else begin
              slot_i <= FW'(slot_i + 1'b1);
              state  <= last_slot ? S_INS_END : S_SLOT_RD;
            end
          end else begin
            cur <= slot_q;
            mj  <= '0;
            if (mc == '0) begin
              mc     <= MW'(mc + 1'b1);
              slot_i <= FW'(slot_i + 1'b1);
              state  <= last_slot ? S_NEXT : S_SLOT_RD;
            end else state <= S_MB_RD;
          end
        end
        S_INS_END: begin
          if (!ins_room) status_r <= ST_FULL;
          state <= S_NEXT;
        end
        S_MB_RD: state <= S_MB_CHK;
        S_MB_CHK: begin
          if (mb_hit | last_j) begin
            if (!mb_hit) mc <= MW'(mc + 1'b1);
            slot_i <= FW'(slot_i + 1'b1);
            state  <= last_slot ? S_NEXT : S_SLOT_RD;
          end else begin
            mj    <= MW'(mj + 1'b1);
            state <= S_MB_RD;
          end
        end
        S_NEXT: begin
          if (XW'(x + 1'b1) == job.x1[XW-1:0]) begin
            x <= job.x0[XW-1:0];
            if (XW'(y + 1'b1) == job.y1[XW-1:0]) state <= S_END;
            else begin
              y     <= XW'(y + 1'b1);
              state <= S_FILL_RD;
            end
          end else begin
            x     <= XW'(x + 1'b1);
            state <= S_FILL_RD;
          end
        end
        S_END: begin
          mj    <= '0;
          state <= (ins || mc == '0) ? S_DONE : S_EMIT_RD;
        end
        S_EMIT_RD: state <= S_EMIT;
        S_EMIT: begin
          if (!res_full) begin
            mj    <= MW'(mj + 1'b1);
            state <= last_j ? S_IDLE : S_EMIT_RD;
          end
        end
        S_DONE: begin
          if (!res_full) begin
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/grid_edge_range_index.sv]
// Top level of the grid edge range index: front, command queue, engine, results.
// Uses gei_pkg, gei_front, gei_fifo and gei_engine.
//
// Items enter through push/full, results leave through empty/pop, one item
// being worked at a time behind a two-entry command queue.
// A clear item empties all cells; an insert widens or appends the chain entry
// of each covered cell; a query merges the covered cells' entries by chain.
// Items pass the front stages and the command queue, then the engine walks the cells.
// Insert: for each covered cell the fill count is read and checked, each slot is
// read and compared until the chain is found, else a last step appends the entry or finds the cell full.
// Query: each covered cell's fill count and every slot are read, each slot is compared
// with the merge-buffer entries in turn, then each result is read and emitted.
// Clear: one fill word per cycle on the fill memory write port over all cells.
// Every item gives at least one result; the last one has last set.
// After reset the fill memory is swept over all cells, during which full stays
// high; configuration writes are taken, as cfg_ready is tied high.
// When the receiver stalls, the result queue fills and the engine holds.
// Configuration must be written only while no item is in flight; the block does not enforce it.
`default_nettype none
module grid_edge_range_index #(
  parameter int GRID_SIDE      = 32,
  parameter int SLOTS_PER_CELL = 8,
  parameter int MAX_RESULTS    = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         action,
  input  wire logic signed [23:0] point_a_x,
  input  wire logic signed [23:0] point_a_y,
  input  wire logic signed [23:0] point_b_x,
  input  wire logic signed [23:0] point_b_y,
  input  wire logic [15:0]        chain_id,
  input  wire logic [15:0]        edge_index,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    has_entry,
  output logic [15:0]             found_chain,
  output logic [15:0]             range_start,
  output logic [15:0]             range_end,
  output logic                    last,
  output logic [1:0]              status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [17:0]        cfg_data
);
  import gei_pkg::*;

  logic signed [17:0] origin_x, origin_y;
  logic [5:0]         size_x, size_y;
  logic               front_full, init_busy;
  cmd_t               f_cmd, e_cmd;
  logic               f_push, q_full, q_empty, e_pop;
  result_t            e_res, o_res;
  logic               r_push, r_full;
  logic [$bits(cmd_t)-1:0]    q_out;
  logic [$bits(result_t)-1:0] r_out;

  assign cfg_ready = 1'b1;
  assign full      = front_full | init_busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      size_x   <= 6'd32;
      size_y   <= 6'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORIGIN_X: origin_x <= cfg_data;
        CFG_ORIGIN_Y: origin_y <= cfg_data;
        CFG_WIDTH:    size_x   <= cfg_data[5:0];
        CFG_HEIGHT:   size_y   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  gei_front #(.GRID_SIDE(GRID_SIDE)) u_front (
    .clk, .rst,
    .push(push & ~init_busy), .full(front_full),
    .action, .point_a_x, .point_a_y, .point_b_x, .point_b_y,
    .chain_id, .edge_index,
    .origin_x, .origin_y, .size_x, .size_y,
    .cmd(f_cmd), .cmd_push(f_push), .cmd_full(q_full)
  );

  gei_fifo #(.W($bits(cmd_t)), .DEPTH(2)) u_cmdq (
    .clk, .rst,
    .wr_en(f_push), .wr_data(f_cmd), .full(q_full),
    .rd_en(e_pop), .rd_data(q_out), .empty(q_empty)
  );
  assign e_cmd = cmd_t'(q_out);

  gei_engine #(
    .GRID_SIDE(GRID_SIDE), .SLOTS_PER_CELL(SLOTS_PER_CELL), .MAX_RESULTS(MAX_RESULTS)
  ) u_engine (
    .clk, .rst,
    .cmd(e_cmd), .cmd_empty(q_empty), .cmd_pop(e_pop),
    .res(e_res), .res_push(r_push), .res_full(r_full),
    .init_busy
  );

  gei_fifo #(.W($bits(result_t)), .DEPTH(2)) u_resq (
    .clk, .rst,
    .wr_en(r_push), .wr_data(e_res), .full(r_full),
    .rd_en(pop), .rd_data(r_out), .empty
  );
  assign o_res = result_t'(r_out);

  assign has_entry   = o_res.has_entry;
  assign found_chain = o_res.found_chain;
  assign range_start = o_res.range_start;
  assign range_end   = o_res.range_end;
  assign last        = o_res.last;
  assign status      = o_res.status;
endmodule
`default_nettype wire

[rtl/gei_checker.sv]
// Port-level checks on the grid edge range index result channel.
// Uses grid_edge_range_index_assert.svh and gei_pkg; bound to the top level below.
`default_nettype none
`include "grid_edge_range_index_assert.svh"
module gei_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        has_entry,
  input wire logic [15:0] found_chain,
  input wire logic        last,
  input wire logic [1:0]  status
);
  import gei_pkg::*;

  // Result records carry a defined status
  `GEI_ASSERT_IMP(a_status_code, clk, rst, !empty, status <= ST_FULL)
  // A merged entry always reports ok
  `GEI_ASSERT_IMP(a_entry_ok, clk, rst, !empty && has_entry, status == ST_OK)
  // A record without an entry closes its item
  `GEI_ASSERT_IMP(a_bare_last, clk, rst, !empty && !has_entry, last)
  // Hold the head result while the receiver stalls
  `GEI_ASSERT_NXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(found_chain))
endmodule

bind grid_edge_range_index gei_checker u_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .has_entry(has_entry),
  .found_chain(found_chain), .last(last), .status(status)
);
`default_nettype wire

[verif/grid_edge_range_index_checker.sv]
// Checker for the grid edge range index: watches item, result and register transfers.
// Predicts the result stream per item and compares it field by field. Uses gei_pkg.
`timescale 1ns / 100ps
module grid_edge_range_index_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         action,
  input  logic signed [23:0] point_a_x,
  input  logic signed [23:0] point_a_y,
  input  logic signed [23:0] point_b_x,
  input  logic signed [23:0] point_b_y,
  input  logic [15:0]        chain_id,
  input  logic [15:0]        edge_index,
  input  logic               empty,
  input  logic               pop,
  input  logic               has_entry,
  input  logic [15:0]        found_chain,
  input  logic [15:0]        range_start,
  input  logic [15:0]        range_end,
  input  logic               last,
  input  logic [1:0]         status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 results_seen
);
  import gei_pkg::*;

  localparam int SIDE = 32;
  localparam int SLOTS = 8;
  localparam int MAX_MERGED = 64;

  // Shadow of the grid and its registers
  longint  org_x, org_y;
  int      size_x, size_y;
  int      cell_count [SIDE*SIDE];
  slot_t   slot_table [SIDE*SIDE*SLOTS];
  result_t expected_results [$];

  // Covered cell span [c0, c1) along one axis
  function automatic void cell_span(input longint a, input longint b, input longint org,
                                    input int size, output longint c0, output longint c1);
    longint lo, hi, lim;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    lim = (size > SIDE) ? SIDE : size;
    c0 = (lo >>> 6) - org;
    c1 = -((-hi) >>> 6) - org;
    if (c0 < 0) c0 = 0;
    if (c1 > lim) c1 = lim;
  endfunction

  function automatic result_t status_only(input logic [1:0] st);
    result_t r;
    r = '0;
    r.last = 1'b1;
    r.status = st;
    return r;
  endfunction

  // Append one expected result at the tail
  function automatic void queue_expect(input result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Work out the results of one accepted item and update the shadow grid
  task automatic predict_item(input logic [1:0] act, input longint ax, input longint ay,
                              input longint bx, input longint by,
                              input logic [15:0] chain, input logic [15:0] edge_idx);
    longint  x0, x1, y0, y1;
    int      cell_idx, n, j, cnt;
    bit      hit, stop_early;
    logic [1:0]  st;
    logic [15:0] eend;
    slot_t   merged [MAX_MERGED];
    slot_t   s;
    result_t r;
    if (act == ACT_CLEAR) begin
      foreach (cell_count[i]) cell_count[i] = 0;
      queue_expect(status_only(ST_OK));
    end else if (act == ACT_NONE) begin
      queue_expect(status_only(ST_OK));
    end else begin
      cell_span(ax, bx, org_x, size_x, x0, x1);
      cell_span(ay, by, org_y, size_y, y0, y1);
      if (act == ACT_INSERT) begin
        eend = (edge_idx == EDGE_MAX) ? EDGE_MAX : edge_idx + 16'd1;
        st = ST_OK;
        for (longint y = y0; y < y1; y++) begin
          for (longint x = x0; x < x1; x++) begin
            cell_idx = int'(y * SIDE + x);
            n = cell_count[cell_idx];
            hit = 0;
            for (int i = 0; i < n && !hit; i++) begin
              if (slot_table[cell_idx*SLOTS+i].chain == chain) begin
                if (edge_idx < slot_table[cell_idx*SLOTS+i].start)
                  slot_table[cell_idx*SLOTS+i].start = edge_idx;
                if (eend > slot_table[cell_idx*SLOTS+i].stop)
                  slot_table[cell_idx*SLOTS+i].stop = eend;
                hit = 1;
              end
            end
            if (!hit) begin
              if (n < SLOTS) begin
                slot_table[cell_idx*SLOTS+n] = '{chain, edge_idx, eend};
                cell_count[cell_idx] = n + 1;
              end else begin
                st = ST_FULL;
              end
            end
          end
        end
        queue_expect(status_only(st));
      end else begin
        // Query: merge covered cells by chain in order of first appearance
        cnt = 0;
        stop_early = 0;
        for (longint y = y0; y < y1 && !stop_early; y++) begin
          for (longint x = x0; x < x1 && !stop_early; x++) begin
            cell_idx = int'(y * SIDE + x);
            n = cell_count[cell_idx];
            if (n != 0) begin
              if (cnt + n > MAX_MERGED) begin
                stop_early = 1;
              end else begin
                for (int i = 0; i < n; i++) begin
                  s = slot_table[cell_idx*SLOTS+i];
                  for (j = 0; j < cnt; j++)
                    if (merged[j].chain == s.chain) break;
                  if (j == cnt) begin
                    merged[cnt] = s;
                    cnt++;
                  end else begin
                    if (s.start < merged[j].start) merged[j].start = s.start;
                    if (s.stop > merged[j].stop) merged[j].stop = s.stop;
                  end
                end
              end
            end
          end
        end
        if (stop_early) begin
          queue_expect(status_only(ST_OVERFLOW));
        end else if (cnt == 0) begin
          queue_expect(status_only(ST_OK));
        end else begin
          for (int k = 0; k < cnt; k++) begin
            r.has_entry = 1'b1;
            r.found_chain = merged[k].chain;
            r.range_start = merged[k].start;
            r.range_end = merged[k].stop;
            r.last = (k == cnt - 1);
            r.status = ST_OK;
            queue_expect(r);
          end
        end
      end
    end
  endtask

  // Track registers, predict on item transfers, compare on result transfers
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      org_x <= 0;
      org_y <= 0;
      size_x <= 32;
      size_y <= 32;
      foreach (cell_count[i]) cell_count[i] = 0;
      expected_results.delete();
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ORIGIN_X: org_x <= longint'($signed(cfg_data));
          CFG_ORIGIN_Y: org_y <= longint'($signed(cfg_data));
          CFG_WIDTH:    size_x <= int'(cfg_data[5:0]);
          CFG_HEIGHT:   size_y <= int'(cfg_data[5:0]);
          default: ;
        endcase
      end
      if (push && !full)
        predict_item(action, longint'(point_a_x), longint'(point_a_y),
                     longint'(point_b_x), longint'(point_b_y), chain_id, edge_index);
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          errors <= errors + 1;
        end else begin
          e = expected_results.pop_front();
          if (has_entry !== e.has_entry || found_chain !== e.found_chain ||
              range_start !== e.range_start || range_end !== e.range_end ||
              last !== e.last || status !== e.status) begin
            errors <= errors + 1;
            if (has_entry !== e.has_entry)
              $error("has_entry: expected %0d, got %0d", e.has_entry, has_entry);
            if (found_chain !== e.found_chain)
              $error("found_chain: expected %0d, got %0d", e.found_chain, found_chain);
            if (range_start !== e.range_start)
              $error("range_start: expected %0d, got %0d", e.range_start, range_start);
            if (range_end !== e.range_end)
              $error("range_end: expected %0d, got %0d", e.range_end, range_end);
            if (last !== e.last)
              $error("last: expected %0d, got %0d", e.last, last);
            if (status !== e.status)
              $error("status: expected %0d, got %0d", e.status, status);
          end
        end
      end
    end
  end

  assign pending = expected_results.size();
endmodule

[verif/testbench.sv]
// Top of the grid edge range index testbench: clock, reset, stimulus and verdict.
// Depends on gei_pkg, grid_edge_range_index and grid_edge_range_index_checker.
`timescale 1ns / 100ps
module testbench;
  import gei_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         action = ACT_NONE;
  logic signed [23:0] point_a_x = '0, point_a_y = '0, point_b_x = '0, point_b_y = '0;
  logic [15:0]        chain_id = '0, edge_index = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               has_entry, last;
  logic [15:0]        found_chain, range_start, range_end;
  logic [1:0]         status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_ORIGIN_X;
  logic [17:0]        cfg_data = '0;
  int                 errors, pending, results_seen;
  int                 items_sent = 0;
  int                 idle_cycles = 0;
  int                 pop_hold = 0;
  longint             org_x = 0, org_y = 0;
  int                 span_x = 32, span_y = 32;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  grid_edge_range_index i_dut (.*);

  grid_edge_range_index_checker i_checker (.*);

  // Receiver: mostly ready, with short and occasional long stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 99) < 15)
        pop_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 3);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Transfer one item; called and returning at a rising edge, push left high
  task automatic send_item(input logic [1:0] act, input longint ax, input longint ay,
                           input longint bx, input longint by,
                           input logic [15:0] chain, input logic [15:0] edge_idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    action <= act;
    point_a_x <= ax[23:0];
    point_a_y <= ay[23:0];
    point_b_x <= bx[23:0];
    point_b_y <= by[23:0];
    chain_id <= chain;
    edge_index <= edge_idx;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // A coordinate inside cell c of the current grid, in 1/16 m
  function automatic longint in_cell(input longint c, input longint org);
    return (c + org) * 64 + $urandom_range(0, 63);
  endfunction

  // Hold off new items and wait until every result is back
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input longint ox, input longint oy, input int w, input int h);
    write_reg(CFG_ORIGIN_X, ox[17:0]);
    write_reg(CFG_ORIGIN_Y, oy[17:0]);
    write_reg(CFG_WIDTH, w[17:0]);
    write_reg(CFG_HEIGHT, h[17:0]);
    org_x = ox;
    org_y = oy;
    span_x = (w > 32) ? 32 : w;
    span_y = (h > 32) ? 32 : h;
  endtask

  function automatic logic [15:0] pick_chain();
    return ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
  endfunction

  // One random item: mostly local inserts and queries, some clears and noise
  task automatic random_item();
    int r;
    longint cx, cy;
    r = $urandom_range(0, 99);
    cx = longint'($urandom_range(0, span_x + 2)) - 2;
    cy = longint'($urandom_range(0, span_y + 2)) - 2;
    if (r < 3) begin
      send_item(ACT_CLEAR, 0, 0, 0, 0, pick_chain(), 16'($urandom));
    end else if (r < 6) begin
      send_item(ACT_NONE, $urandom, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom));
    end else if (r < 14) begin
      send_item(2'($urandom_range(1, 2)), $urandom, $urandom, $urandom, $urandom,
                16'($urandom), 16'($urandom));
    end else if (r < 62) begin
      send_item(ACT_INSERT, in_cell(cx, org_x), in_cell(cy, org_y),
                in_cell(cx + $urandom_range(0, 2), org_x),
                in_cell(cy + $urandom_range(0, 1), org_y),
                pick_chain(), ($urandom_range(0, 9) == 0) ? EDGE_MAX : 16'($urandom));
    end else begin
      send_item(ACT_QUERY, in_cell(cx + $urandom_range(0, 4), org_x), in_cell(cy, org_y),
                in_cell(cx, org_x), in_cell(cy + $urandom_range(0, 4), org_y), 0, 0);
    end
  endtask

  // Fill a 3x3 block with distinct chains, query it past and within the merge limit, then clear
  task automatic flood_block();
    for (int k = 0; k < 72; k++)
      send_item(ACT_INSERT, in_cell(k % 3, org_x), in_cell((k / 3) % 3, org_y),
                in_cell(k % 3, org_x), in_cell((k / 3) % 3, org_y),
                16'(1000 + k), 16'($urandom));
    send_item(ACT_QUERY, in_cell(0, org_x), in_cell(0, org_y),
              in_cell(2, org_x), in_cell(2, org_y), 0, 0);
    send_item(ACT_QUERY, in_cell(0, org_x), in_cell(0, org_y),
              in_cell(1, org_x), in_cell(2, org_y), 0, 0);
    send_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: widening, saturation, empty ranges, full cell, grid extremes
    send_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    send_item(ACT_INSERT, 10, 10, 20, 20, 16'd5, 16'd10);
    send_item(ACT_INSERT, 12, 30, 12, 30, 16'd5, 16'd3);
    send_item(ACT_INSERT, 5, 5, 6, 6, 16'd5, EDGE_MAX);
    send_item(ACT_INSERT, 70, 70, 100, 100, 16'd6, 16'd0);
    send_item(ACT_QUERY, 1, 1, 100, 100, 0, 0);
    send_item(ACT_QUERY, 650, 650, 660, 660, 0, 0);
    send_item(ACT_INSERT, 64, 64, 64, 64, 16'd9, 16'd1);
    send_item(ACT_NONE, -1, -1, -1, -1, 16'hFFFF, 16'hFFFF);
    send_item(ACT_INSERT, -8388608, -8388608, 8388607, 8388607, 16'hFFFF, 16'd40);
    send_item(ACT_QUERY, 8388607, 8388607, -8388608, -8388608, 0, 0);
    for (int k = 0; k < 9; k++)
      send_item(ACT_INSERT, 200, 200, 200, 200, 16'(20 + k), 16'(k));
    send_item(ACT_QUERY, 130, 130, 250, 250, 0, 0);
    send_item(ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    drain();

    // Random phases over several grid settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_grid(-3, 5, 32, 32);
        1: set_grid(0, 0, 0, 7);
        2: set_grid(2, -2, 63, 40);
        3: set_grid(-131072, 131071, 1, 1);
        4: set_grid(131071, -131072, 33, 2);
        default: set_grid(0, 0, 32, 32);
      endcase
      if (ph == 0 || ph == 5) flood_block();
      repeat (ph == 3 || ph == 4 ? 12 : 22) random_item();
      drain();
    end

    $display("covered %0d items and %0d results over six grid settings,", items_sent,
             results_seen);
    $display("including full cells, merge overflow, clears and saturated edge ends");
    if (errors == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/gei_pkg.sv
rtl/gei_fifo.sv
rtl/gei_front.sv
rtl/gei_engine.sv
rtl/grid_edge_range_index.sv
rtl/gei_checker.sv
verif/grid_edge_range_index_checker.sv
verif/testbench.sv
